/* hw/rtl/svg_pkg.sv */
package svg_pkg;

   localparam int IDX_W = 9;
   localparam int ANG_W = 16;
   localparam int POS_W = 18;
   localparam int TRIG_W = 17;
   localparam int CORDIC_STEPS = 14;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam logic [IDX_W-1:0] MAX_SEGMENTS = 9'd256;

   localparam logic [2:0] CSR_COLUMN_COUNT = 3'd0;
   localparam logic [2:0] CSR_RING_COUNT = 3'd1;
   localparam logic [2:0] CSR_RADIUS = 3'd2;
   localparam logic [2:0] CSR_OFFSET_X = 3'd3;
   localparam logic [2:0] CSR_OFFSET_Y = 3'd4;

   localparam logic signed [POS_W-1:0] POS_MAX = 18'sd131071;
   localparam logic signed [POS_W-1:0] POS_MIN = -18'sd131072;
   localparam logic signed [TRIG_W-1:0] CORDIC_START = 17'sd19898;

   // angles queued between front and back
   typedef struct packed {
      logic [ANG_W-1:0] pol;
      logic [ANG_W-1:0] az;
      logic [IDX_W-1:0] ring;
      logic [IDX_W-1:0] col;
      logic             bad;
   } job_type;

   function automatic logic signed [TRIG_W-1:0] atan_turns(input logic [3:0] i);
      logic signed [TRIG_W-1:0] v;
      case (i)
         4'd0: v = 17'sd8192;
         4'd1: v = 17'sd4836;
         4'd2: v = 17'sd2555;
         4'd3: v = 17'sd1297;
         4'd4: v = 17'sd651;
         4'd5: v = 17'sd326;
         4'd6: v = 17'sd163;
         4'd7: v = 17'sd81;
         4'd8: v = 17'sd41;
         4'd9: v = 17'sd20;
         4'd10: v = 17'sd10;
         4'd11: v = 17'sd5;
         4'd12: v = 17'sd3;
         4'd13: v = 17'sd1;
         default: v = 17'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [47:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 48'(POS_MAX)) begin
         r = POS_MAX;
      end else if (v < 48'(POS_MIN)) begin
         r = POS_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/svg_divider.sv */
// pipelined restoring divide: quot = num / den, num < den * 2^17, den in 1..256
// one quotient bit per stage, 17 quotient bits needed
module svg_divider (
   input  logic        clock,
   input  logic        enable,
   input  logic [24:0] num,
   input  logic [8:0]  den,
   output logic [16:0] quot
);
   localparam int NSTG = 17;

   logic [24:0] rem_ff [NSTG+1];
   logic [16:0] q_ff [NSTG+1];
   logic [8:0]  d_ff [NSTG+1];

   always_comb begin
      rem_ff[0] = num;
      q_ff[0] = '0;
      d_ff[0] = den;
   end

   genvar g;
   generate
      for (g = 0; g < NSTG; g++) begin : g_stg
         logic [24:0] rem_in;
         logic [16:0] q_in;
         logic [25:0] dsh;
         always_comb begin
            dsh = 26'(d_ff[g]) << (NSTG-1-g);
            if (26'(rem_ff[g]) >= dsh) begin
               rem_in = rem_ff[g] - dsh[24:0];
               q_in = q_ff[g] | (17'd1 << (NSTG-1-g));
            end else begin
               rem_in = rem_ff[g];
               q_in = q_ff[g];
            end
         end
         logic [24:0] r_ff;
         logic [16:0] qq_ff;
         logic [8:0]  dd_ff;
         always_ff @(posedge clock) begin
            if (enable) begin
               r_ff <= rem_in;
               qq_ff <= q_in;
               dd_ff <= d_ff[g];
            end
         end
         always_comb begin
            rem_ff[g+1] = r_ff;
            q_ff[g+1] = qq_ff;
            d_ff[g+1] = dd_ff;
         end
      end
   endgenerate

   assign quot = q_ff[NSTG];
endmodule

/* hw/rtl/svg_front.sv */
// front: classify the point and turn indices into angles
module svg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [8:0]           req_ring_index,
   input  logic [8:0]           req_column_index,
   input  logic [8:0]           column_count,
   input  logic [8:0]           ring_count,
   output logic                 job_valid,
   output svg_pkg::job_type     job,
   input  logic                 job_full
);
   localparam int LAT = 17;

   logic              adv;
   logic [LAT-1:0]    vld_ff;
   logic [LAT-1:0]    vld_in;
   logic [8:0]        ring_ff [LAT+1];
   logic [8:0]        col_ff [LAT+1];
   logic              bad_ff [LAT+1];
   logic              bad;
   logic [16:0]       pol_q;
   logic [16:0]       az_q;
   logic [8:0]        rc;
   logic [8:0]        cc;

   // whole pipe holds while the queue is full and the last stage has an item
   assign adv = !(job_full && vld_ff[LAT-1]);
   assign req_stall = !adv;

   assign bad = column_count == '0 || ring_count == '0 ||
                column_count > svg_pkg::MAX_SEGMENTS ||
                ring_count > svg_pkg::MAX_SEGMENTS ||
                req_ring_index > ring_count || req_column_index > column_count;
   // safe denominators for bad points
   assign rc = bad ? 9'd1 : ring_count;
   assign cc = bad ? 9'd1 : column_count;

   svg_divider u_div_pol (
      .clock(clock), .enable(adv),
      .num({1'b0, req_ring_index, 15'd0}), .den(rc), .quot(pol_q)
   );
   svg_divider u_div_az (
      .clock(clock), .enable(adv),
      .num({req_column_index, 16'd0}), .den(cc), .quot(az_q)
   );

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      ring_ff[0] = req_ring_index;
      col_ff[0] = req_column_index;
      bad_ff[0] = bad;
   end

   genvar g;
   generate
      for (g = 0; g < LAT; g++) begin : g_side
         logic [8:0] r_ff;
         logic [8:0] c_ff;
         logic       b_ff;
         always_ff @(posedge clock) begin
            if (adv) begin
               r_ff <= ring_ff[g];
               c_ff <= col_ff[g];
               b_ff <= bad_ff[g];
            end
         end
         always_comb begin
            ring_ff[g+1] = r_ff;
            col_ff[g+1] = c_ff;
            bad_ff[g+1] = b_ff;
         end
      end
   endgenerate

   assign job_valid = vld_ff[LAT-1] && !job_full;
   always_comb begin
      job.pol = pol_q[15:0];
      job.az = az_q[15:0];
      job.ring = ring_ff[LAT];
      job.col = col_ff[LAT];
      job.bad = bad_ff[LAT];
   end
endmodule

/* hw/rtl/svg_queue.sv */
// small fifo between front and back; full leaves room for nothing in flight
module svg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  svg_pkg::job_type push_data,
   output logic             full,
   output logic             pop_valid,
   output svg_pkg::job_type pop_data,
   input  logic             pop
);
   svg_pkg::job_type mem_ff [svg_pkg::QDEPTH];
   logic [svg_pkg::QPTR_W-1:0] wp_ff, rp_ff;
   logic [svg_pkg::QPTR_W:0]   cnt_ff;
   logic do_pop;

   assign do_pop = pop && pop_valid;
   assign full = cnt_ff == (svg_pkg::QPTR_W+1)'(svg_pkg::QDEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (do_pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (svg_pkg::QPTR_W+1)'(push) - (svg_pkg::QPTR_W+1)'(do_pop);
      end
   end
endmodule

/* hw/rtl/svg_back.sv */
// back: cordic for both angles, then scale, offset and saturate
module svg_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  svg_pkg::job_type job,
   output logic             job_pop,
   input  logic [15:0]      radius,
   input  logic signed [15:0] offset_x,
   input  logic signed [15:0] offset_y,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic signed [17:0] rsp_pos_x,
   output logic signed [17:0] rsp_pos_y,
   output logic signed [17:0] rsp_pos_z,
   output logic [8:0]       rsp_tex_u,
   output logic [8:0]       rsp_tex_v,
   output logic             rsp_point_invalid
);
   localparam int NS = svg_pkg::CORDIC_STEPS;
   localparam int W = svg_pkg::TRIG_W;
   // stages: 1 prep, NS cordic, 1 flip, 1 mul a, 1 mul b, 1 out
   localparam int LAT = NS + 5;

   logic adv;
   logic [LAT-1:0] vld_ff;

   assign adv = !(rsp_valid && rsp_stall);
   assign job_pop = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], job_valid};
      end
   end
   assign rsp_valid = vld_ff[LAT-1];

   // cordic lanes: 0 polar, 1 azimuth
   logic signed [W-1:0] cx_ff [2][NS+1];
   logic signed [W-1:0] cy_ff [2][NS+1];
   logic signed [W-1:0] cz_ff [2][NS+1];
   logic                fl_ff [2][NS+1];
   logic [8:0]  ring_ff [NS+5];
   logic [8:0]  col_ff [NS+5];
   logic        bad_ff [NS+5];

   // angles in the second and third quadrant turn by half a turn first
   logic [15:0] pa, aa;
   logic        pf, af;
   always_comb begin
      pf = (job.pol >= 16'd16384) && (job.pol < 16'd49152);
      af = (job.az >= 16'd16384) && (job.az < 16'd49152);
      pa = pf ? job.pol + 16'd32768 : job.pol;
      aa = af ? job.az + 16'd32768 : job.az;
   end

   // prep stage
   always_ff @(posedge clock) begin
      if (adv) begin
         fl_ff[0][0] <= pf;
         cx_ff[0][0] <= svg_pkg::CORDIC_START;
         cy_ff[0][0] <= '0;
         cz_ff[0][0] <= W'($signed(pa));
         fl_ff[1][0] <= af;
         cx_ff[1][0] <= svg_pkg::CORDIC_START;
         cy_ff[1][0] <= '0;
         cz_ff[1][0] <= W'($signed(aa));
         ring_ff[0] <= job.ring;
         col_ff[0] <= job.col;
         bad_ff[0] <= job.bad;
      end
   end

   genvar g, ln;
   generate
      for (ln = 0; ln < 2; ln++) begin : g_lane
         for (g = 0; g < NS; g++) begin : g_rot
            always_ff @(posedge clock) begin
               if (adv) begin
                  if (!cz_ff[ln][g][W-1]) begin
                     cx_ff[ln][g+1] <= cx_ff[ln][g] - (cy_ff[ln][g] >>> g);
                     cy_ff[ln][g+1] <= cy_ff[ln][g] + (cx_ff[ln][g] >>> g);
                     cz_ff[ln][g+1] <= cz_ff[ln][g] - svg_pkg::atan_turns(4'(g));
                  end else begin
                     cx_ff[ln][g+1] <= cx_ff[ln][g] + (cy_ff[ln][g] >>> g);
                     cy_ff[ln][g+1] <= cy_ff[ln][g] - (cx_ff[ln][g] >>> g);
                     cz_ff[ln][g+1] <= cz_ff[ln][g] + svg_pkg::atan_turns(4'(g));
                  end
                  fl_ff[ln][g+1] <= fl_ff[ln][g];
               end
            end
         end
      end
      for (g = 0; g < NS + 4; g++) begin : g_side
         always_ff @(posedge clock) begin
            if (adv) begin
               ring_ff[g+1] <= ring_ff[g];
               col_ff[g+1] <= col_ff[g];
               bad_ff[g+1] <= bad_ff[g];
            end
         end
      end
   endgenerate

   // flip stage
   logic signed [W-1:0] cp_ff, sp_ff, ca_ff, sa_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         cp_ff <= fl_ff[0][NS] ? -cx_ff[0][NS] : cx_ff[0][NS];
         sp_ff <= fl_ff[0][NS] ? -cy_ff[0][NS] : cy_ff[0][NS];
         ca_ff <= fl_ff[1][NS] ? -cx_ff[1][NS] : cx_ff[1][NS];
         sa_ff <= fl_ff[1][NS] ? -cy_ff[1][NS] : cy_ff[1][NS];
      end
   end

   // first multiply: sin(pol)*radius and cos(pol)*radius
   logic signed [34:0] spr_ff, cpr_ff;
   logic signed [W-1:0] ca2_ff, sa2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         spr_ff <= sp_ff * $signed({1'b0, radius});
         cpr_ff <= cp_ff * $signed({1'b0, radius});
         ca2_ff <= ca_ff;
         sa2_ff <= sa_ff;
      end
   end

   // second multiply
   logic signed [51:0] xp_ff, zp_ff;
   logic signed [34:0] cpr2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         xp_ff <= spr_ff * ca2_ff;
         zp_ff <= spr_ff * sa2_ff;
         cpr2_ff <= cpr_ff;
      end
   end

   // round, offset, saturate
   logic signed [51:0] xr, zr;
   logic signed [34:0] yr;
   logic signed [47:0] xs, ys, zs;
   always_comb begin
      xr = (xp_ff + 52'sd536870912) >>> 30;
      zr = (zp_ff + 52'sd536870912) >>> 30;
      yr = (cpr2_ff + 35'sd16384) >>> 15;
      xs = 48'(xr) + 48'(offset_x);
      ys = 48'(yr) + 48'(offset_y);
      zs = 48'(zr);
   end

   logic signed [17:0] px_ff, py_ff, pz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= bad_ff[NS+3] ? '0 : svg_pkg::sat_pos(xs);
         py_ff <= bad_ff[NS+3] ? '0 : svg_pkg::sat_pos(ys);
         pz_ff <= bad_ff[NS+3] ? '0 : svg_pkg::sat_pos(zs);
      end
   end

   assign rsp_pos_x = px_ff;
   assign rsp_pos_y = py_ff;
   assign rsp_pos_z = pz_ff;
   assign rsp_tex_u = col_ff[NS+4];
   assign rsp_tex_v = ring_ff[NS+4];
   assign rsp_point_invalid = bad_ff[NS+4];
endmodule

/* hw/rtl/sphere_vertex_generator_core.sv */
// channel | dir | handshake          | payload
// req     | in  | req_valid/stall    | ring_index, column_index
// rsp     | out | rsp_valid/stall    | pos_x/y/z, tex_u/v, point_invalid
// csr     | in  | csr_write_enable   | csr_index, csr_write_data
// one item per cycle sustained unless req_stall or rsp_stall holds the flow;
// a request passes 17 angle divider stages, the queue and 19 back stages (14 cordic)
// synchronous reset clears valid pipes, queue and registers to defaults
// rsp_stall freezes the back pipe; the queue then fills and raises req_stall
module sphere_vertex_generator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [8:0]         req_ring_index,
   input  logic [8:0]         req_column_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_pos_x,
   output logic signed [17:0] rsp_pos_y,
   output logic signed [17:0] rsp_pos_z,
   output logic [8:0]         rsp_tex_u,
   output logic [8:0]         rsp_tex_v,
   output logic               rsp_point_invalid,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data
);
   logic [8:0]         column_count_ff, ring_count_ff;
   logic [15:0]        radius_ff;
   logic signed [15:0] offset_x_ff, offset_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 9'd10;
         ring_count_ff <= 9'd10;
         radius_ff <= 16'd2560;
         offset_x_ff <= 16'sd6400;
         offset_y_ff <= 16'sd6400;
      end else if (csr_write_enable) begin
         case (csr_index)
            svg_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_write_data[8:0];
            svg_pkg::CSR_RING_COUNT: ring_count_ff <= csr_write_data[8:0];
            svg_pkg::CSR_RADIUS: radius_ff <= csr_write_data;
            svg_pkg::CSR_OFFSET_X: offset_x_ff <= $signed(csr_write_data);
            svg_pkg::CSR_OFFSET_Y: offset_y_ff <= $signed(csr_write_data);
            default: ;
         endcase
      end
   end

   logic             f_valid, q_full, q_valid, q_pop;
   svg_pkg::job_type f_job, q_job;

   svg_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ring_index(req_ring_index), .req_column_index(req_column_index),
      .column_count(column_count_ff), .ring_count(ring_count_ff),
      .job_valid(f_valid), .job(f_job), .job_full(q_full)
   );

   svg_queue u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid), .push_data(f_job), .full(q_full),
      .pop_valid(q_valid), .pop_data(q_job), .pop(q_pop)
   );

   svg_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job(q_job), .job_pop(q_pop),
      .radius(radius_ff), .offset_x(offset_x_ff), .offset_y(offset_y_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v),
      .rsp_point_invalid(rsp_point_invalid)
   );
endmodule
